>>> rtl/grd_pkg.sv
// ----------------------------------------------------------------------------
// grd_pkg
// Types, widths, the exp table and the derivative order decoder shared by the
// Gaussian radial basis derivative pipeline.
// ----------------------------------------------------------------------------
package grd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int EXP_ENTRIES  = 256;
    localparam int EXP_SPAN     = 16;
    localparam int EXP_SPAN_LOG = 4;
    localparam int IDX_W        = 8;
    localparam int FRC_W        = FRAC_BITS + EXP_SPAN_LOG - IDX_W;

    localparam int POS_W    = 24;
    localparam int D_W      = POS_W + 1;
    localparam int SQ_W     = 2 * D_W - 1;
    localparam int R2_W     = SQ_W + 1;
    localparam int R2_LO_W  = R2_W / 2;
    localparam int E2_W     = 32;
    localparam int PP_W     = R2_LO_W + E2_W;
    localparam int PROD_W   = R2_W + E2_W;
    localparam int T_LSB    = 2 * FRAC_BITS;
    localparam int FAR_LSB  = T_LSB + FRAC_BITS + EXP_SPAN_LOG;
    localparam int DQ_W     = SQ_W - FRAC_BITS;
    localparam int SM_W     = DQ_W + E2_W;
    localparam int S_W      = SM_W - FRAC_BITS + 2;
    localparam int G_W      = FRAC_BITS + 1;
    localparam int IP_W     = G_W + FRC_W;

    localparam int MAG_W    = 62;
    localparam int OPD_W    = S_W - 1;
    localparam int A_LO_W   = 32;
    localparam int A_HI_W   = MAG_W - A_LO_W;
    localparam int B_LO_W   = OPD_W / 2;
    localparam int B_HI_W   = OPD_W - B_LO_W;
    localparam int FULL_W   = MAG_W + OPD_W;
    localparam int SLOTS    = 6;

    localparam int OUT_W    = 48;
    localparam int WIDE_W   = MAG_W + 3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS         = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_SQ = 1'd1;
    localparam logic [1:0]      DIMS_RESET  = 2'd3;
    localparam logic [E2_W-1:0] SCALE_RESET = 32'd6553600;

    localparam logic [1:0] ORD_NONE = 2'd0;
    localparam logic [1:0] ORD_ONE  = 2'd1;
    localparam logic [1:0] ORD_TWO  = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [2:0] {
        OP_PASS,
        OP_DX,
        OP_DY,
        OP_DZ,
        OP_E2,
        OP_S
    } op_t;

    typedef struct packed {
        op_t [SLOTS-1:0] ops;
        logic [1:0]      shift;
        logic [1:0]      s_axis;
        logic            bad;
    } plan_t;

    typedef struct packed {
        logic signed [D_W-1:0] d_x;
        logic signed [D_W-1:0] d_y;
        logic signed [D_W-1:0] d_z;
        logic signed [S_W-1:0] s;
        plan_t                 plan;
    } ctl_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        ctl_t             ctl;
    } val_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_a_x;
        logic signed [POS_W-1:0] pos_a_y;
        logic signed [POS_W-1:0] pos_a_z;
        logic signed [POS_W-1:0] pos_b_x;
        logic signed [POS_W-1:0] pos_b_y;
        logic signed [POS_W-1:0] pos_b_z;
        logic [1:0]              deriv_x;
        logic [1:0]              deriv_y;
        logic [1:0]              deriv_z;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] basis_value;
        logic                    bad_order;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [E2_W-1:0]      value;
    } cfg_t;

    typedef logic [G_W-1:0] exp_rom_t [0:EXP_ENTRIES];

    // shift-and-subtract quotient, used only while the table is built
    function automatic logic [63:0] const_quot(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-EXP_SPAN*i/N) in Q.16, built by repeated multiplication by a
    // Q.58 series for exp(-EXP_SPAN/N)
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t     rom;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  e;
        logic [127:0] prod;
        sum  = 64'd1 << 58;
        term = sum;
        e    = sum;
        for (int k = 1; k <= 40; k++)
        begin
            term = const_quot(term * 64'(EXP_SPAN), 64'(EXP_ENTRIES) * 64'(k));
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int i = 0; i <= EXP_ENTRIES; i++)
        begin
            if (i > 0)
            begin
                prod = 128'(e) * 128'(sum);
                e    = prod[121:58];
            end
            rom[i] = G_W'((e + (64'd1 << (57 - FRAC_BITS))) >> (58 - FRAC_BITS));
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    function automatic plan_t order_plan(logic [1:0] dx, logic [1:0] dy, logic [1:0] dz);
        plan_t p;
        for (int k = 0; k < SLOTS; k++)
        begin
            p.ops[k] = OP_PASS;
        end
        p.shift  = 2'd0;
        p.s_axis = AX_X;
        p.bad    = 1'b0;
        unique case ({dx, dy, dz})
            {ORD_NONE, ORD_NONE, ORD_NONE}: ;
            {ORD_ONE, ORD_NONE, ORD_NONE}:
            begin
                p.ops[0] = OP_DX;
                p.ops[1] = OP_E2;
                p.shift  = 2'd1;
            end
            {ORD_NONE, ORD_ONE, ORD_NONE}:
            begin
                p.ops[0] = OP_DY;
                p.ops[1] = OP_E2;
                p.shift  = 2'd1;
            end
            {ORD_NONE, ORD_NONE, ORD_ONE}:
            begin
                p.ops[0] = OP_DZ;
                p.ops[1] = OP_E2;
                p.shift  = 2'd1;
            end
            {ORD_TWO, ORD_NONE, ORD_NONE}:
            begin
                p.ops[0] = OP_S;
                p.ops[1] = OP_E2;
                p.shift  = 2'd1;
                p.s_axis = AX_X;
            end
            {ORD_NONE, ORD_TWO, ORD_NONE}:
            begin
                p.ops[0] = OP_S;
                p.ops[1] = OP_E2;
                p.shift  = 2'd1;
                p.s_axis = AX_Y;
            end
            {ORD_NONE, ORD_NONE, ORD_TWO}:
            begin
                p.ops[0] = OP_S;
                p.ops[1] = OP_E2;
                p.shift  = 2'd1;
                p.s_axis = AX_Z;
            end
            {ORD_ONE, ORD_ONE, ORD_NONE}:
            begin
                p.ops[0] = OP_DX;
                p.ops[1] = OP_DY;
                p.ops[2] = OP_E2;
                p.ops[3] = OP_E2;
                p.shift  = 2'd2;
            end
            {ORD_ONE, ORD_NONE, ORD_ONE}:
            begin
                p.ops[0] = OP_DX;
                p.ops[1] = OP_DZ;
                p.ops[2] = OP_E2;
                p.ops[3] = OP_E2;
                p.shift  = 2'd2;
            end
            {ORD_NONE, ORD_ONE, ORD_ONE}:
            begin
                p.ops[0] = OP_DY;
                p.ops[1] = OP_DZ;
                p.ops[2] = OP_E2;
                p.ops[3] = OP_E2;
                p.shift  = 2'd2;
            end
            {ORD_ONE, ORD_ONE, ORD_ONE}:
            begin
                p.ops[0] = OP_DX;
                p.ops[1] = OP_DY;
                p.ops[2] = OP_DZ;
                p.ops[3] = OP_E2;
                p.ops[4] = OP_E2;
                p.ops[5] = OP_E2;
                p.shift  = 2'd3;
            end
            default:
            begin
                p.bad = 1'b1;
            end
        endcase
        return p;
    endfunction

endpackage

>>> rtl/grd_if.sv
// ----------------------------------------------------------------------------
// grd_if
// Valid/ready channels: input word, result word and register writes.
// ----------------------------------------------------------------------------
interface grd_item_if
    import grd_pkg::*;
;
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface grd_result_if
    import grd_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface grd_cfg_if
    import grd_pkg::*;
;
    logic valid;
    logic ready;
    cfg_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/grd_gauss.sv
// ----------------------------------------------------------------------------
// grd_gauss
// Offset, squared radius, exponent argument, interpolated exp table and the
// second-order factor s. Seven register stages.
// ----------------------------------------------------------------------------
module grd_gauss
    import grd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      dims,
    input  logic [E2_W-1:0] inv_scale_sq,
    input  logic            in_valid,
    output logic            in_ready,
    input  item_t           in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output val_t            out_word
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   en;
    ctl_t              ctl_reg [STAGES];
    ctl_t              ctl0_next;
    ctl_t              ctl4_next;

    logic signed [2*D_W-1:0] sq_full [3];
    logic [SQ_W-1:0]         sq_reg  [3];
    logic [R2_W-1:0]         r2_reg;
    logic [DQ_W-1:0]         dq_next;
    logic [DQ_W-1:0]         dq_reg;
    logic [PP_W-1:0]         plo_reg;
    logic [PP_W-1:0]         phi_reg;
    logic [SM_W-1:0]         sm_reg;
    logic [PROD_W-1:0]       prod;
    logic signed [S_W-1:0]   s_next;
    logic                    far_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [FRC_W-1:0]        frc_reg;
    logic [G_W-1:0]          top_reg;
    logic [G_W-1:0]          diff_reg;
    logic [FRC_W-1:0]        frc5_reg;
    logic                    far5_reg;
    logic [IP_W-1:0]         ip;
    logic [G_W-1:0]          g_next;
    logic [G_W-1:0]          g_reg;
    logic [G_W-1:0]          top_next;
    logic [G_W-1:0]          bot_next;

    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    always_comb
    begin
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            v_next[k] = en[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage 0: offsets over the used axes, order decode
    always_comb
    begin
        ctl0_next.d_x = (dims != 2'd0)
            ? D_W'(in_word.pos_a_x) - D_W'(in_word.pos_b_x) : '0;
        ctl0_next.d_y = (dims >= 2'd2)
            ? D_W'(in_word.pos_a_y) - D_W'(in_word.pos_b_y) : '0;
        ctl0_next.d_z = (dims == 2'd3)
            ? D_W'(in_word.pos_a_z) - D_W'(in_word.pos_b_z) : '0;
        ctl0_next.s    = '0;
        ctl0_next.plan = order_plan(in_word.deriv_x, in_word.deriv_y, in_word.deriv_z);
    end

    // stage 1: squares
    assign sq_full[0] = ctl_reg[0].d_x * ctl_reg[0].d_x;
    assign sq_full[1] = ctl_reg[0].d_y * ctl_reg[0].d_y;
    assign sq_full[2] = ctl_reg[0].d_z * ctl_reg[0].d_z;

    // stage 2: radius and the squared offset for s
    always_comb
    begin
        case (ctl_reg[1].plan.s_axis)
            AX_X:    dq_next = sq_reg[0][SQ_W-1:FRAC_BITS];
            AX_Y:    dq_next = sq_reg[1][SQ_W-1:FRAC_BITS];
            default: dq_next = sq_reg[2][SQ_W-1:FRAC_BITS];
        endcase
    end

    // stage 4: exponent argument split into index and fraction, s formed
    assign prod   = {phi_reg, R2_LO_W'(0)} + PROD_W'(plo_reg);
    assign s_next = $signed({1'b0, sm_reg[SM_W-1:FRAC_BITS], 1'b0}) - S_W'(1 << FRAC_BITS);

    always_comb
    begin
        ctl4_next   = ctl_reg[3];
        ctl4_next.s = s_next;
    end

    // stage 5: table read
    assign top_next = EXP_ROM[{1'b0, idx_reg}];
    assign bot_next = EXP_ROM[{1'b0, idx_reg} + (IDX_W + 1)'(1)];

    // stage 6: linear interpolation
    assign ip     = diff_reg * frc5_reg;
    assign g_next = far5_reg ? '0 : top_reg - ip[IP_W-1:FRC_W];

    always_ff @(posedge clk)
    begin
        if (en[0])
            ctl_reg[0] <= ctl0_next;
        if (en[1])
        begin
            ctl_reg[1] <= ctl_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_full[i][SQ_W-1:0];
            end
        end
        if (en[2])
        begin
            ctl_reg[2] <= ctl_reg[1];
            r2_reg     <= R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);
            dq_reg     <= dq_next;
        end
        if (en[3])
        begin
            ctl_reg[3] <= ctl_reg[2];
            plo_reg    <= PP_W'(r2_reg[R2_LO_W-1:0]) * PP_W'(inv_scale_sq);
            phi_reg    <= PP_W'(r2_reg[R2_W-1:R2_LO_W]) * PP_W'(inv_scale_sq);
            sm_reg     <= SM_W'(dq_reg) * SM_W'(inv_scale_sq);
        end
        if (en[4])
        begin
            ctl_reg[4] <= ctl4_next;
            far_reg    <= |prod[PROD_W-1:FAR_LSB];
            idx_reg    <= prod[FAR_LSB-1 -: IDX_W];
            frc_reg    <= prod[T_LSB +: FRC_W];
        end
        if (en[5])
        begin
            ctl_reg[5] <= ctl_reg[4];
            top_reg    <= top_next;
            diff_reg   <= top_next - bot_next;
            frc5_reg   <= frc_reg;
            far5_reg   <= far_reg;
        end
        if (en[6])
        begin
            ctl_reg[6] <= ctl_reg[5];
            g_reg      <= g_next;
        end
    end

    assign out_word = '{neg: 1'b0, mag: MAG_W'(g_reg), ctl: ctl_reg[6]};

endmodule

>>> rtl/grd_qmul.sv
// ----------------------------------------------------------------------------
// grd_qmul
// One Q.16 multiply slot: sign/magnitude product by the operand that the
// word's next op names, truncated and clamped to 2^62-1. Two stages.
// ----------------------------------------------------------------------------
module grd_qmul
    import grd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [E2_W-1:0] inv_scale_sq,
    input  logic            in_valid,
    output logic            in_ready,
    input  val_t            in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output val_t            out_word
);

    localparam int STAGES = 2;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   en;

    op_t                   op;
    logic                  b_neg;
    logic [OPD_W-1:0]      b_mag;
    logic                  pass;
    logic signed [D_W-1:0] d_abs;
    logic signed [S_W-1:0] s_abs;
    val_t                  hold_next;

    logic [A_LO_W+B_LO_W-1:0] p_ll_reg;
    logic [A_LO_W+B_HI_W-1:0] p_lh_reg;
    logic [A_HI_W+B_LO_W-1:0] p_hl_reg;
    logic [A_HI_W+B_HI_W-1:0] p_hh_reg;
    logic                     neg_reg;
    logic                     pass_reg;
    val_t                     hold_reg;
    val_t                     res_next;
    val_t                     res_reg;

    logic [FULL_W-1:0] full;
    logic              clamp;
    logic [MAG_W-1:0]  mag_next;

    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    assign v_next[0] = en[0] ? in_valid : v_reg[0];
    assign v_next[1] = en[1] ? v_reg[0] : v_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // operand select
    assign op = in_word.ctl.plan.ops[0];

    always_comb
    begin
        b_neg = 1'b0;
        b_mag = '0;
        pass  = 1'b0;
        d_abs = '0;
        s_abs = '0;
        case (op)
            OP_DX:
            begin
                d_abs = in_word.ctl.d_x[D_W-1] ? -in_word.ctl.d_x : in_word.ctl.d_x;
                b_neg = in_word.ctl.d_x[D_W-1];
                b_mag = OPD_W'($unsigned(d_abs));
            end
            OP_DY:
            begin
                d_abs = in_word.ctl.d_y[D_W-1] ? -in_word.ctl.d_y : in_word.ctl.d_y;
                b_neg = in_word.ctl.d_y[D_W-1];
                b_mag = OPD_W'($unsigned(d_abs));
            end
            OP_DZ:
            begin
                d_abs = in_word.ctl.d_z[D_W-1] ? -in_word.ctl.d_z : in_word.ctl.d_z;
                b_neg = in_word.ctl.d_z[D_W-1];
                b_mag = OPD_W'($unsigned(d_abs));
            end
            OP_E2:
            begin
                b_mag = OPD_W'(inv_scale_sq);
            end
            OP_S:
            begin
                s_abs = in_word.ctl.s[S_W-1] ? -in_word.ctl.s : in_word.ctl.s;
                b_neg = in_word.ctl.s[S_W-1];
                b_mag = s_abs[OPD_W-1:0];
            end
            default:
            begin
                pass = 1'b1;
            end
        endcase
    end

    // consume this slot's op
    always_comb
    begin
        hold_next = in_word;
        for (int k = 0; k < SLOTS - 1; k++)
        begin
            hold_next.ctl.plan.ops[k] = in_word.ctl.plan.ops[k + 1];
        end
        hold_next.ctl.plan.ops[SLOTS-1] = OP_PASS;
    end

    // partial products recombined, truncated by the fraction, clamped
    assign full = FULL_W'(p_ll_reg)
                + (FULL_W'(p_lh_reg) << B_LO_W)
                + (FULL_W'(p_hl_reg) << A_LO_W)
                + (FULL_W'(p_hh_reg) << (A_LO_W + B_LO_W));
    assign clamp    = |full[FULL_W-1:MAG_W+FRAC_BITS];
    assign mag_next = clamp ? {MAG_W{1'b1}} : full[MAG_W+FRAC_BITS-1:FRAC_BITS];

    always_comb
    begin
        res_next = hold_reg;
        if (!pass_reg)
        begin
            res_next.mag = mag_next;
            res_next.neg = neg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_ll_reg <= (A_LO_W+B_LO_W)'(in_word.mag[A_LO_W-1:0])
                      * (A_LO_W+B_LO_W)'(b_mag[B_LO_W-1:0]);
            p_lh_reg <= (A_LO_W+B_HI_W)'(in_word.mag[A_LO_W-1:0])
                      * (A_LO_W+B_HI_W)'(b_mag[OPD_W-1:B_LO_W]);
            p_hl_reg <= (A_HI_W+B_LO_W)'(in_word.mag[MAG_W-1:A_LO_W])
                      * (A_HI_W+B_LO_W)'(b_mag[B_LO_W-1:0]);
            p_hh_reg <= (A_HI_W+B_HI_W)'(in_word.mag[MAG_W-1:A_LO_W])
                      * (A_HI_W+B_HI_W)'(b_mag[OPD_W-1:B_LO_W]);
            neg_reg  <= in_word.neg ^ b_neg;
            pass_reg <= pass;
            hold_reg <= hold_next;
        end
        if (en[1])
            res_reg <= res_next;
    end

    assign out_word = res_reg;

endmodule

>>> rtl/grd_out.sv
// ----------------------------------------------------------------------------
// grd_out
// Final power-of-two factor, saturation to signed Q32.16 and the output
// register.
// ----------------------------------------------------------------------------
module grd_out
    import grd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  val_t    in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic              v_reg;
    logic              en;
    logic [WIDE_W-1:0] wide;
    logic              big;
    result_t           res_next;
    result_t           res_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    assign wide = WIDE_W'(in_word.mag) << in_word.ctl.plan.shift;
    assign big  = |wide[WIDE_W-1:OUT_W-1];

    always_comb
    begin
        res_next.bad_order = in_word.ctl.plan.bad;
        if (in_word.ctl.plan.bad)
            res_next.basis_value = '0;
        else if (big)
            res_next.basis_value = in_word.neg ? OUT_MIN : OUT_MAX;
        else if (in_word.neg)
            res_next.basis_value = -$signed(wide[OUT_W-1:0]);
        else
            res_next.basis_value = $signed(wide[OUT_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = v_reg;
    assign out_word  = res_reg;

endmodule

>>> rtl/gaussian_rbf_derivative.sv
// ----------------------------------------------------------------------------
// gaussian_rbf_derivative
// Gaussian radial basis value and its low-order partial derivatives.
// From input word to result word: the exp pipeline, 6 multiply slots and
// the output register. Throughput: one word per cycle while the output is
// not stalled; each stage holds or collapses bubbles.
// Reset clears the pipeline; dims resets to 3, inv_scale_sq to 6553600.
// ----------------------------------------------------------------------------
module gaussian_rbf_derivative
    import grd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    grd_item_if.sink      item,
    grd_result_if.source  result,
    grd_cfg_if.sink       cfg
);

    logic [1:0]      dims_reg;
    logic [E2_W-1:0] scale_reg;

    logic [SLOTS:0] link_valid;
    logic [SLOTS:0] link_ready;
    val_t           link_word [SLOTS+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= DIMS_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_DIMS:         dims_reg  <= cfg.data.value[1:0];
                REG_INV_SCALE_SQ: scale_reg <= cfg.data.value;
                default:          ;
            endcase
        end
    end

    grd_gauss u_gauss
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims_reg),
        .inv_scale_sq (scale_reg),
        .in_valid     (item.valid),
        .in_ready     (item.ready),
        .in_word      (item.data),
        .out_valid    (link_valid[0]),
        .out_ready    (link_ready[0]),
        .out_word     (link_word[0])
    );

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_slot
        grd_qmul u_qmul
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .inv_scale_sq (scale_reg),
            .in_valid     (link_valid[k]),
            .in_ready     (link_ready[k]),
            .in_word      (link_word[k]),
            .out_valid    (link_valid[k+1]),
            .out_ready    (link_ready[k+1]),
            .out_word     (link_word[k+1])
        );
    end

    grd_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[SLOTS]),
        .in_ready  (link_ready[SLOTS]),
        .in_word   (link_word[SLOTS]),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_word  (result.data)
    );

    // an empty output register never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> item.ready)
        else $error("input stalled with output register empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.bad_order |-> result.data.basis_value == '0)
        else $error("unsupported order gave a non-zero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.data.index == REG_INV_SCALE_SQ
        |=> scale_reg == $past(cfg.data.value))
        else $error("scale register write lost");

endmodule

>>> tb/tb_gaussian_rbf_derivative.sv
// ----------------------------------------------------------------------------
// tb_gaussian_rbf_derivative
// Self-checking bench for the Gaussian radial basis derivative pipeline. A
// directed table walks the order codes, the range limits, zero dims and the
// scale extremes, then random words run under several register settings and
// idle profiles. Each result word is checked against a bit-true predictor.
// ----------------------------------------------------------------------------
module tb_gaussian_rbf_derivative;
    import grd_pkg::*;

    localparam longint unsigned MAG_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint          V_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          V_MIN   = -64'sh0000_8000_0000_0000;
    localparam longint          ONE_Q   = 64'sd65536;
    localparam longint unsigned GSPAN   = 64'd16 << 16;

    typedef struct {
        logic [1:0]  dims;
        logic [31:0] e2;
        item_t       w;
        bit          chk;
        result_t     want;
    } row_t;

    logic clk;
    logic rst_n;

    grd_item_if   item_ch ();
    grd_result_if res_ch ();
    grd_cfg_if    cfg_ch ();

    gaussian_rbf_derivative uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    logic [63:0] exp_tab [0:256];
    logic [1:0]  cur_dims;
    logic [31:0] cur_e2;
    result_t     expect_q [$];
    row_t        rows [$];
    int          n_fail;
    int          send_gap;
    int          recv_gap;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void make_exp_tab();
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  e;
        logic [127:0] p;
        sum  = 64'd1 << 58;
        term = sum;
        e    = sum;
        for (int k = 1; k <= 40; k++)
        begin
            term = (term * 64'd16) / (64'd256 * 64'(k));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int i = 0; i <= 256; i++)
        begin
            if (i > 0)
            begin
                p = {64'd0, e} * {64'd0, sum};
                e = 64'(p >> 58);
            end
            exp_tab[i] = (e + (64'd1 << 41)) >> 42;
        end
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  m;
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        p  = {64'd0, ua} * {64'd0, ub};
        p  = p >> 16;
        m  = (p > {64'd0, MAG_LIM}) ? MAG_LIM : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint gauss_of(logic [63:0] r2, logic [63:0] e2);
        logic [127:0] p;
        logic [63:0]  t;
        logic [63:0]  u;
        logic [63:0]  k;
        logic [63:0]  rem;
        p = {64'd0, r2} * {64'd0, e2};
        if ((p >> 96) != 0)
            return 0;
        t = p[95:32];
        if (t >= GSPAN)
            return 0;
        u   = t * 64'd256;
        k   = u / GSPAN;
        rem = u % GSPAN;
        if (k >= 256)
            return 0;
        return longint'(exp_tab[k] - ((exp_tab[k] - exp_tab[k+1]) * rem) / GSPAN);
    endfunction

    function automatic result_t basis_of(item_t w);
        longint      d [3];
        longint      v;
        longint      e2;
        longint      s;
        logic [63:0] r2;
        int          code;
        int          lin;
        int          sq;
        result_t     r;
        d[0] = $signed(w.pos_a_x) - $signed(w.pos_b_x);
        d[1] = $signed(w.pos_a_y) - $signed(w.pos_b_y);
        d[2] = $signed(w.pos_a_z) - $signed(w.pos_b_z);
        r2   = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (i >= cur_dims)
                d[i] = 0;
            r2 = r2 + 64'(d[i] * d[i]);
        end
        e2   = longint'({32'd0, cur_e2});
        v    = gauss_of(r2, 64'(e2));
        code = int'(w.deriv_x) + 10 * int'(w.deriv_y) + 100 * int'(w.deriv_z);
        lin  = -1;
        sq   = -1;
        r.bad_order = 1'b0;
        case (code)
            0: ;
            1: lin = 0;
            10: lin = 1;
            100: lin = 2;
            2: sq = 0;
            20: sq = 1;
            200: sq = 2;
            11: begin v = fx_mul(fx_mul(v, d[0]), d[1]); lin = 3; end
            101: begin v = fx_mul(fx_mul(v, d[0]), d[2]); lin = 3; end
            110: begin v = fx_mul(fx_mul(v, d[1]), d[2]); lin = 3; end
            111:
            begin
                v = fx_mul(fx_mul(fx_mul(v, d[0]), d[1]), d[2]);
                v = fx_mul(fx_mul(fx_mul(v, e2), e2), e2);
                v = fx_mul(v, 8 * ONE_Q);
            end
            default:
            begin
                r.bad_order = 1'b1;
                v = 0;
            end
        endcase
        if (lin >= 0 && lin < 3)
        begin
            v = fx_mul(fx_mul(v, d[lin]), e2);
            v = fx_mul(v, 2 * ONE_Q);
        end
        else if (lin == 3)
        begin
            v = fx_mul(fx_mul(v, e2), e2);
            v = fx_mul(v, 4 * ONE_Q);
        end
        if (sq >= 0)
        begin
            s = 2 * fx_mul(e2, fx_mul(d[sq], d[sq])) - ONE_Q;
            v = fx_mul(fx_mul(v, s), e2);
            v = fx_mul(v, 2 * ONE_Q);
        end
        if (v > V_MAX)
            v = V_MAX;
        if (v < V_MIN)
            v = V_MIN;
        r.basis_value = v[47:0];
        return r;
    endfunction

    task automatic add_row(logic [1:0] dm, logic [31:0] e2,
                           logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                           logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                           logic [1:0] ox, logic [1:0] oy, logic [1:0] oz,
                           bit chk, logic [47:0] val, logic bad);
        row_t r;
        r.dims = dm;
        r.e2   = e2;
        r.w    = '{ax, ay, az, bx, by, bz, ox, oy, oz};
        r.chk  = chk;
        r.want = '{val, bad};
        rows.push_back(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        wait (expect_q.size() == 0);
        repeat (25) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = '{idx, val};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_DIMS)
            cur_dims = val[1:0];
        else
            cur_e2 = val;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_regs(logic [1:0] dm, logic [31:0] e2);
        if (dm != cur_dims)
            write_reg(REG_DIMS, {30'd0, dm});
        if (e2 != cur_e2)
            write_reg(REG_INV_SCALE_SQ, e2);
    endtask

    task automatic send_word(item_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_gap)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.data  = w;
        do
            @(posedge clk);
        while (!item_ch.ready);
        expect_q.push_back(basis_of(w));
    endtask

    task automatic end_burst();
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    function automatic item_t random_word();
        item_t       w;
        logic [23:0] dl [3];
        w = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 75)
        begin
            if ($urandom_range(1) == 0)
            begin
                w.pos_b_x = '0;
                w.pos_b_y = '0;
                w.pos_b_z = '0;
            end
            for (int i = 0; i < 3; i++)
                dl[i] = $signed(24'($urandom)) >>> $urandom_range(4, 23);
            w.pos_a_x = w.pos_b_x + dl[0];
            w.pos_a_y = w.pos_b_y + dl[1];
            w.pos_a_z = w.pos_b_z + dl[2];
        end
        if ($urandom_range(99) < 80)
        begin
            case ($urandom_range(10))
                0: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_NONE, ORD_NONE, ORD_NONE};
                1: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_ONE, ORD_NONE, ORD_NONE};
                2: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_NONE, ORD_ONE, ORD_NONE};
                3: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_NONE, ORD_NONE, ORD_ONE};
                4: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_TWO, ORD_NONE, ORD_NONE};
                5: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_NONE, ORD_TWO, ORD_NONE};
                6: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_NONE, ORD_NONE, ORD_TWO};
                7: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_ONE, ORD_ONE, ORD_NONE};
                8: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_ONE, ORD_NONE, ORD_ONE};
                9: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_NONE, ORD_ONE, ORD_ONE};
                default: {w.deriv_x, w.deriv_y, w.deriv_z} = {ORD_ONE, ORD_ONE, ORD_ONE};
            endcase
        end
        return w;
    endfunction

    // result word checker
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (expect_q.size() == 0)
                begin
                    $display("%0t: unexpected word %h/%b", $time,
                             res_ch.data.basis_value, res_ch.data.bad_order);
                    n_fail++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (res_ch.data.basis_value !== want.basis_value)
                    begin
                        $display("%0t: basis_value exp %h got %h", $time,
                                 want.basis_value, res_ch.data.basis_value);
                        n_fail++;
                    end
                    if (res_ch.data.bad_order !== want.bad_order)
                    begin
                        $display("%0t: bad_order exp %b got %b", $time,
                                 want.bad_order, res_ch.data.bad_order);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = ($urandom_range(99) >= recv_gap);
        end
    end

    initial
    begin
        logic [1:0]  rnd_dims [6];
        logic [31:0] rnd_e2 [6];
        n_fail        = 0;
        send_gap      = 0;
        recv_gap      = 0;
        stall_left    = 0;
        cur_dims      = DIMS_RESET;
        cur_e2        = SCALE_RESET;
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        make_exp_tab();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(3, SCALE_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 48'd65536, 0);
        for (int k = 0; k < 11; k++)
            add_row(3, 32'h10000, 24'h008000, 24'h004000, 24'hFFA000, 0, 0, 0,
                    (k == 1 || k == 7 || k == 8 || k == 10) ? ORD_ONE :
                    (k == 4) ? ORD_TWO : ORD_NONE,
                    (k == 2 || k == 7 || k == 9 || k == 10) ? ORD_ONE :
                    (k == 5) ? ORD_TWO : ORD_NONE,
                    (k == 3 || k == 8 || k == 9 || k == 10) ? ORD_ONE :
                    (k == 6) ? ORD_TWO : ORD_NONE, 0, 0, 0);
        add_row(3, 32'h10000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                24'h800000, 24'h800000, 24'h800000, 0, 0, 0, 1, 0, 0);
        add_row(3, 32'h10000, 24'h800000, 24'h800000, 24'h800000,
                24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 1, 1, 1, 0, 0);
        add_row(3, 32'h10000, 24'h001000, 0, 0, 0, 0, 0, 3, 0, 0, 1, 0, 1);
        add_row(3, 32'h10000, 24'h001000, 0, 0, 0, 0, 0, 1, 2, 0, 1, 0, 1);
        add_row(3, 32'h10000, 24'h001000, 0, 0, 0, 0, 0, 3, 3, 3, 1, 0, 1);
        add_row(3, 32'h10000, 24'h001000, 0, 0, 0, 0, 0, 2, 2, 0, 1, 0, 1);
        add_row(3, 32'h10000, 24'h001000, 0, 0, 0, 0, 0, 0, 1, 2, 1, 0, 1);
        add_row(0, 32'h10000, 24'h123456, 24'h654321, 24'h0ABCDE, 0, 0, 0,
                0, 0, 0, 1, 48'd65536, 0);
        add_row(0, 32'h10000, 24'h123456, 24'h654321, 24'h0ABCDE, 0, 0, 0,
                0, 2, 0, 0, 0, 0);
        add_row(3, 32'h0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0, 0,
                0, 0, 0, 1, 48'd65536, 0);
        add_row(3, 32'h0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0, 0,
                1, 1, 1, 0, 0, 0);
        add_row(1, 32'hFFFFFFFF, 24'h000001, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(1, 32'hFFFFFFFF, 24'h7FFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);

        foreach (rows[i])
        begin
            if (rows[i].dims != cur_dims || rows[i].e2 != cur_e2)
            begin
                end_burst();
                set_regs(rows[i].dims, rows[i].e2);
            end
            send_word(rows[i].w);
            if (rows[i].chk && basis_of(rows[i].w) !== rows[i].want)
            begin
                $display("%0t: table row %0d exp %h/%b got %h/%b", $time, i,
                         rows[i].want.basis_value, rows[i].want.bad_order,
                         expect_q[$].basis_value, expect_q[$].bad_order);
                n_fail++;
            end
            if (rows[i].chk)
                expect_q[$] = rows[i].want;
        end
        end_burst();

        rnd_dims = '{3, 1, 2, 3, 2, 1};
        rnd_e2   = '{32'h10000, 32'd4, 32'hFFFFFFFF, 32'd1, 32'h100000, 32'h30000};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_regs(rnd_dims[ph], rnd_e2[ph]);
            send_gap = (ph < 2) ? 18 : (ph < 4) ? 64 : 0;
            recv_gap = (ph < 2) ? 64 : (ph < 4) ? 18 : 0;
            for (int n = 0; n < 80; n++)
            begin
                if (ph == 4 && n == 20)
                    stall_left = 300;
                if (ph == 5 && n == 40)
                begin
                    end_burst();
                    wait (expect_q.size() == 0);
                end
                send_word(random_word());
            end
            end_burst();
        end

        wait (expect_q.size() == 0);
        repeat (40) @(posedge clk);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
